>>> rtl/sjfs_pkg.sv
package sjfs_pkg;

  // process table depth
  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  // field widths
  localparam int ARR_W  = 16;
  localparam int TIME_W = 21;
  localparam int PIDX_W = 4;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // stream word widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ARR_W-1:0]  arr_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [QA_W-1:0]   qptr_t;
  typedef logic [QC_W-1:0]   qcnt_t;

  // one classified word handed from front to back
  typedef struct packed {
    arr_t arrival;
    arr_t burst;
    logic store;
    logic last;
  } q_entry_t;

endpackage

>>> rtl/sjfs_front.sv
module sjfs_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sjfs_pkg::IN_DATA_W-1:0]     in_tdata,  // arrival_time, burst_time
  input  logic                               in_tlast,  // last_process
  input  logic                               q_full,
  output logic                               q_push,
  output sjfs_pkg::q_entry_t                 q_data
);

  sjfs_pkg::cnt_t cnt_r, cnt_nxt;
  logic           accept;
  logic           room;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign room      = (cnt_r < sjfs_pkg::cnt_t'(sjfs_pkg::MAX_PROCS));

  // overflow words are dropped unless they close the batch, which passes without store
  assign q_push         = accept && (room || in_tlast);
  assign q_data.arrival = in_tdata[15:0];
  assign q_data.burst   = in_tdata[31:16];
  assign q_data.store   = room;
  assign q_data.last    = in_tlast;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_tlast) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/sjfs_fifo.sv
module sjfs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sjfs_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output sjfs_pkg::q_entry_t pop_data,
  output logic               empty
);

  sjfs_pkg::q_entry_t mem [sjfs_pkg::Q_DEPTH];
  sjfs_pkg::qptr_t    wr_r, wr_nxt, rd_r, rd_nxt;
  sjfs_pkg::qcnt_t    cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == sjfs_pkg::qcnt_t'(sjfs_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_r];

  function automatic sjfs_pkg::qptr_t ptr_inc(input sjfs_pkg::qptr_t p);
    if (p == sjfs_pkg::qptr_t'(sjfs_pkg::Q_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  always_comb begin
    wr_nxt  = do_push ? ptr_inc(wr_r) : wr_r;
    rd_nxt  = do_pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/sjfs_back.sv
module sjfs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  sjfs_pkg::q_entry_t                q_data,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sjfs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  // process table
  sjfs_pkg::arr_t  arr_mem [sjfs_pkg::MAX_PROCS];
  sjfs_pkg::arr_t  bur_mem [sjfs_pkg::MAX_PROCS];
  sjfs_pkg::time_t fin_mem [sjfs_pkg::MAX_PROCS];
  logic [sjfs_pkg::MAX_PROCS-1:0] done_r, done_nxt;

  logic [1:0]      state_r, state_nxt;
  sjfs_pkg::cnt_t  cnt_r, cnt_nxt;
  sjfs_pkg::cnt_t  remain_r, remain_nxt;
  sjfs_pkg::time_t time_r, time_nxt;
  sjfs_pkg::idx_t  scan_r, scan_nxt;
  logic            have_pick_r, have_pick_nxt;
  sjfs_pkg::idx_t  pick_r, pick_nxt;
  sjfs_pkg::arr_t  pick_bur_r, pick_bur_nxt;
  logic            have_pend_r, have_pend_nxt;
  sjfs_pkg::arr_t  pend_r, pend_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [sjfs_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                            out_last_r, out_last_nxt;

  logic            load_wr, fin_wr;
  sjfs_pkg::idx_t  load_idx;
  sjfs_pkg::arr_t  scan_arr, scan_bur;
  logic            scan_end;
  sjfs_pkg::time_t ct, tat, wt;
  logic [sjfs_pkg::IDX_W+sjfs_pkg::PIDX_W-1:0] pidx_ext;
  logic            out_load;

  assign load_idx = sjfs_pkg::idx_t'(cnt_r);
  assign scan_arr = arr_mem[scan_r];
  assign scan_bur = bur_mem[scan_r];
  assign scan_end = (sjfs_pkg::cnt_t'(scan_r) + 1'b1 == cnt_r);

  // result fields of the entry at the scan index
  assign ct       = fin_mem[scan_r];
  assign tat      = ct - sjfs_pkg::time_t'(scan_arr);
  assign wt       = tat - sjfs_pkg::time_t'(scan_bur);
  assign pidx_ext = {{sjfs_pkg::PIDX_W{1'b0}}, scan_r};

  assign q_pop    = (state_r == ST_LOAD) && !q_empty;
  assign load_wr  = q_pop && q_data.store;
  assign fin_wr   = (state_r == ST_COMMIT) && have_pick_r;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    remain_nxt    = remain_r;
    time_nxt      = time_r;
    scan_nxt      = scan_r;
    have_pick_nxt = have_pick_r;
    pick_nxt      = pick_r;
    pick_bur_nxt  = pick_bur_r;
    have_pend_nxt = have_pend_r;
    pend_nxt      = pend_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_LOAD: begin
        if (q_pop) begin
          if (q_data.store) begin
            done_nxt[load_idx] = 1'b0;
            cnt_nxt            = cnt_r + 1'b1;
          end
          if (q_data.last) begin
            state_nxt     = ST_SCAN;
            remain_nxt    = q_data.store ? cnt_r + 1'b1 : cnt_r;
            time_nxt      = '0;
            scan_nxt      = '0;
            have_pick_nxt = 1'b0;
            have_pend_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (!done_r[scan_r]) begin
          if (sjfs_pkg::time_t'(scan_arr) <= time_r) begin
            // strict less keeps the lowest index on a tie
            if (!have_pick_r || scan_bur < pick_bur_r) begin
              have_pick_nxt = 1'b1;
              pick_nxt      = scan_r;
              pick_bur_nxt  = scan_bur;
            end
          end else if (!have_pend_r || scan_arr < pend_r) begin
            have_pend_nxt = 1'b1;
            pend_nxt      = scan_arr;
          end
        end
        if (scan_end) begin
          state_nxt = ST_COMMIT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_COMMIT: begin
        scan_nxt      = '0;
        have_pick_nxt = 1'b0;
        have_pend_nxt = 1'b0;
        state_nxt     = ST_SCAN;
        if (have_pick_r) begin
          time_nxt         = time_r + sjfs_pkg::time_t'(pick_bur_r);
          done_nxt[pick_r] = 1'b1;
          remain_nxt       = remain_r - 1'b1;
          if (remain_r == sjfs_pkg::cnt_t'(1)) begin
            state_nxt = ST_EMIT;
          end
        end else begin
          // idle: jump to the earliest pending arrival
          time_nxt = sjfs_pkg::time_t'(pend_r);
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, tat, wt, ct, pidx_ext[sjfs_pkg::PIDX_W-1:0]};
          out_last_nxt  = scan_end;
          if (scan_end) begin
            // batch finished: clear for the next one
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            time_nxt  = '0;
            done_nxt  = '0;
            scan_nxt  = '0;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      arr_mem[load_idx] <= q_data.arrival;
      bur_mem[load_idx] <= q_data.burst;
    end
    if (fin_wr) begin
      fin_mem[pick_r] <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    pick_r       <= pick_nxt;
    pick_bur_r   <= pick_bur_nxt;
    pend_r       <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      remain_r    <= '0;
      time_r      <= '0;
      scan_r      <= '0;
      have_pick_r <= 1'b0;
      have_pend_r <= 1'b0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      remain_r    <= remain_nxt;
      time_r      <= time_nxt;
      scan_r      <= scan_nxt;
      have_pick_r <= have_pick_nxt;
      have_pend_r <= have_pend_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/sjf_nonpreemptive_scheduler.sv
// channel   dir  data bits (low first)                                  tlast
// in_       in   [15:0] arrival_time, [31:16] burst_time                 last_process
// out_      out  [3:0] process_index, [24:4] completion_time,            last_result
//                [45:25] waiting_time, [66:46] turnaround_time, pad 0
//
// loading: one word a cycle, while the queue has room, through a two-word queue into the process table
// scheduling: each pick scans the whole table and then commits the shortest ready burst;
// a scan that finds nothing ready moves time to the earliest pending arrival and scans again
// results: one word a cycle while out_tready is high, in load order from a registered output stage
// rst_n synchronous active low clears control state and the done flags
// input stalls only when the queue is full; the back end stalls on out_tready
module sjf_nonpreemptive_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sjfs_pkg::IN_DATA_W-1:0]  in_tdata,   // arrival_time, burst_time
  input  logic                            in_tlast,   // last_process
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sjfs_pkg::OUT_DATA_W-1:0] out_tdata,  // index, completion, waiting, turnaround
  output logic                            out_tlast   // last_result
);

  // classified words between front and back
  logic               q_push, q_full, q_pop, q_empty;
  sjfs_pkg::q_entry_t q_wdata, q_rdata;

  // front: accepts words, drops overflow, tags store and last
  sjfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // short queue so loading can run ahead of scheduling
  sjfs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: process table, shortest-burst scan and result stream
  sjfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
